>>> sv/bcds_pkg.sv
// ----------------------------------------------------------------------------
// bcds_pkg
// Shared widths, types and the double-dabble step function for the binary to
// BCD digit serialiser.
// ----------------------------------------------------------------------------
package bcds_pkg;

   localparam int VALUE_W    = 32;
   localparam int MAX_DIGITS = 10;
   localparam int DIGIT_W    = 4;
   localparam int BCD_W      = DIGIT_W * MAX_DIGITS;
   localparam int CNT_W      = 4;
   localparam int DAB_STEPS  = 8;
   localparam int STAGES     = VALUE_W / DAB_STEPS;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [0:0] REG_DIGIT_COUNT = 1'b0;

   typedef struct packed {
      logic [VALUE_W-1:0] bin;
      logic [BCD_W-1:0]   bcd;
      logic [CNT_W-1:0]   cnt;
   } stage_type;

   typedef struct packed {
      logic [BCD_W-1:0] bcd;
      logic [CNT_W-1:0] cnt;
   } conv_type;

   // One group of double-dabble iterations: every digit of five or more is
   // corrected by three, then the BCD and binary words shift left together.
   function automatic stage_type dabble(stage_type s);
      stage_type r;
      r = s;
      for (int i = 0; i < DAB_STEPS; i++) begin
         for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r.bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
               r.bcd[d*DIGIT_W +: DIGIT_W] = r.bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
         end
         r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
         r.bin = {r.bin[VALUE_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

>>> sv/bcds_req_if.sv
// ----------------------------------------------------------------------------
// bcds_req_if
// Input channel: one binary value per transfer.
// ----------------------------------------------------------------------------
interface bcds_req_if;
   logic                          valid;
   logic                          ready;
   logic [bcds_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

>>> sv/bcds_rsp_if.sv
// ----------------------------------------------------------------------------
// bcds_rsp_if
// Result channel: one BCD digit with its select index per transfer.
// ----------------------------------------------------------------------------
interface bcds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bcds_pkg::DIGIT_W-1:0]  bcd_digit;
   logic [bcds_pkg::CNT_W-1:0]    position;
   logic                          last;

   modport source (output valid, output bcd_digit, output position, output last,
                   input ready);
   modport sink   (input valid, input bcd_digit, input position, input last,
                   output ready);
endinterface

>>> sv/bcds_convert.sv
// ----------------------------------------------------------------------------
// bcds_convert
// Pipelined double-dabble converter: each stage performs a fixed group of
// shift-and-correct iterations, with a valid bit and local stall per stage.
// ----------------------------------------------------------------------------
module bcds_convert (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [bcds_pkg::VALUE_W-1:0] in_value,
   input  logic [bcds_pkg::CNT_W-1:0]   in_cnt,
   output logic                         out_valid,
   input  logic                         out_ready,
   output bcds_pkg::conv_type           out_data
);

   bcds_pkg::stage_type             stage_ff [bcds_pkg::STAGES];
   bcds_pkg::stage_type             stage_in [bcds_pkg::STAGES];
   logic [bcds_pkg::STAGES-1:0]     valid_ff;
   logic [bcds_pkg::STAGES-1:0]     valid_in;
   logic [bcds_pkg::STAGES-1:0]     adv;
   bcds_pkg::stage_type             entry;

   // A stage may take new data when it is empty or its contents move on.
   always_comb begin
      for (int k = bcds_pkg::STAGES - 1; k >= 0; k--) begin
         if (k == bcds_pkg::STAGES - 1) begin
            adv[k] = !valid_ff[k] || out_ready;
         end else begin
            adv[k] = !valid_ff[k] || adv[k+1];
         end
      end
   end

   always_comb begin
      entry.bin = in_value;
      entry.bcd = '0;
      entry.cnt = in_cnt;
      for (int k = 0; k < bcds_pkg::STAGES; k++) begin
         if (k == 0) begin
            stage_in[k] = bcds_pkg::dabble(entry);
            valid_in[k] = adv[k] ? in_valid : valid_ff[k];
         end else begin
            stage_in[k] = bcds_pkg::dabble(stage_ff[k-1]);
            valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int k = 0; k < bcds_pkg::STAGES; k++) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready     = adv[0];
   assign out_valid    = valid_ff[bcds_pkg::STAGES-1];
   assign out_data.bcd = stage_ff[bcds_pkg::STAGES-1].bcd;
   assign out_data.cnt = stage_ff[bcds_pkg::STAGES-1].cnt;

endmodule

>>> sv/bcds_serial.sv
// ----------------------------------------------------------------------------
// bcds_serial
// Digit serialiser: holds one converted value and presents its digits, most
// significant first, one per result transfer from registered outputs.
// ----------------------------------------------------------------------------
module bcds_serial (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  bcds_pkg::conv_type  in_data,
   bcds_rsp_if.source          rsp
);

   logic [bcds_pkg::BCD_W-1:0] dig_ff, dig_in;
   logic [bcds_pkg::CNT_W-1:0] pos_ff, pos_in;
   logic [bcds_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       last_ff, last_in;
   logic                       load;
   logic [5:0]                 shamt;
   logic [bcds_pkg::CNT_W-1:0] gap;

   always_comb begin
      in_ready = !busy_ff || (rsp.ready && last_ff);
      load     = in_valid && in_ready;
      gap      = bcds_pkg::CNT_W'(bcds_pkg::MAX_DIGITS) - in_data.cnt;
      shamt    = {gap, 2'b00};
      dig_in   = dig_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      last_in  = last_ff;
      if (load) begin
         // Left-align the kept digits so the most significant sits on top.
         dig_in  = in_data.bcd << shamt;
         pos_in  = '0;
         cnt_in  = in_data.cnt;
         busy_in = (in_data.cnt != '0);
         last_in = (in_data.cnt == bcds_pkg::CNT_W'(1));
      end else if (busy_ff && rsp.ready) begin
         dig_in  = {dig_ff[bcds_pkg::BCD_W-bcds_pkg::DIGIT_W-1:0],
                    {bcds_pkg::DIGIT_W{1'b0}}};
         pos_in  = pos_ff + bcds_pkg::CNT_W'(1);
         busy_in = !last_ff;
         last_in = (pos_ff + bcds_pkg::CNT_W'(2) == cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      dig_ff  <= dig_in;
      pos_ff  <= pos_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
   end

   assign rsp.valid     = busy_ff;
   assign rsp.bcd_digit = dig_ff[bcds_pkg::BCD_W-1 -: bcds_pkg::DIGIT_W];
   assign rsp.position  = pos_ff;
   assign rsp.last      = last_ff;

endmodule

>>> sv/binary_to_bcd_digit_serializer_core.sv
// A transferred value passes through four conversion stages and then the digit
// output register before its first digit shows.
// Throughput: one digit per cycle on the result channel while the result side is ready;
// the digit register takes the next value when the last digit of the one it holds is
// taken, and a value with a digit count of zero sends no digits.
// Reset: digit_count returns to 3 and the pipeline and digit register empty.
// ----------------------------------------------------------------------------
// binary_to_bcd_digit_serializer_core
// Converts 32-bit binary values to BCD and sends the low digit_count digits,
// most significant first, each with its digit-select index and a last flag.
// ----------------------------------------------------------------------------
module binary_to_bcd_digit_serializer_core (
   input  logic                            clock,
   input  logic                            reset,
   bcds_req_if.sink                        req_chan,
   bcds_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bcds_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bcds_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bcds_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [bcds_pkg::CNT_W-1:0] digit_count_ff, digit_count_in;
   logic [bcds_pkg::CNT_W-1:0] eff_cnt;
   logic                       conv_valid;
   logic                       conv_ready;
   bcds_pkg::conv_type         conv_data;
   logic                       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == bcds_pkg::REG_DIGIT_COUNT);

   always_comb begin
      digit_count_in = wr_en ? csr_pwdata[bcds_pkg::CNT_W-1:0] : digit_count_ff;
      csr_prdata     = '0;
      if (csr_paddr[2] == bcds_pkg::REG_DIGIT_COUNT) begin
         csr_prdata = bcds_pkg::CSR_DATA_W'(digit_count_ff);
      end
      // Counts above the digit capacity saturate.
      if (digit_count_ff > bcds_pkg::CNT_W'(bcds_pkg::MAX_DIGITS)) begin
         eff_cnt = bcds_pkg::CNT_W'(bcds_pkg::MAX_DIGITS);
      end else begin
         eff_cnt = digit_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= bcds_pkg::CNT_W'(3);
      end else begin
         digit_count_ff <= digit_count_in;
      end
   end

   bcds_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_value  (req_chan.value),
      .in_cnt    (eff_cnt),
      .out_valid (conv_valid),
      .out_ready (conv_ready),
      .out_data  (conv_data)
   );

   bcds_serial u_serial (
      .clock    (clock),
      .reset    (reset),
      .in_valid (conv_valid),
      .in_ready (conv_ready),
      .in_data  (conv_data),
      .rsp      (rsp_chan)
   );

endmodule

>>> sv/bcds_checker.sv
// ----------------------------------------------------------------------------
// bcds_checker
// Port-level checks on the result channel of the digit serialiser.
// ----------------------------------------------------------------------------
module bcds_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bcds_pkg::DIGIT_W-1:0] rsp_bcd_digit,
   input logic [bcds_pkg::CNT_W-1:0]   rsp_position,
   input logic                         rsp_last
);

   // A stalled digit holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bcd_digit)
         && $stable(rsp_position) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bcd_digit <= bcds_pkg::DIGIT_W'(9))
      else $error("digit is not decimal");

   // Digits of one value follow without a gap and with rising positions.
   a_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_position == bcds_pkg::CNT_W'($past(rsp_position) + 1'b1))
      else $error("digit sequence broken");

   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid || rsp_position == '0)
      else $error("new value does not start at position zero");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind binary_to_bcd_digit_serializer_core bcds_checker u_bcds_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_bcd_digit (rsp_chan.bcd_digit),
   .rsp_position  (rsp_chan.position),
   .rsp_last      (rsp_chan.last)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the binary to BCD digit serialiser. A short table of directed
// values and register writes runs first, followed by random values over a range
// of digit counts, with random gaps on both channels and one long output stall.
// Each digit is checked against typed rows or a decimal conversion done here.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 20;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 80;
   localparam int REPORT_LIMIT   = 10;
   localparam int NUM_ROWS       = 29;
   localparam int NUM_BLOCKS     = 9;
   localparam int PAD_W          = bcds_pkg::CSR_DATA_W - bcds_pkg::CNT_W;

   localparam logic [bcds_pkg::CSR_ADDR_W-1:0] ADDR_DIGIT_COUNT =
      bcds_pkg::CSR_ADDR_W'({bcds_pkg::REG_DIGIT_COUNT, 2'b00});
   localparam logic [bcds_pkg::CSR_ADDR_W-1:0] ADDR_UNMAPPED    =
      bcds_pkg::CSR_ADDR_W'(4);

   typedef enum logic {ROW_WRITE, ROW_VALUE} row_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic [bcds_pkg::CSR_ADDR_W-1:0]   addr;
      logic [bcds_pkg::VALUE_W-1:0]      word;
      logic                              typed;
      logic [bcds_pkg::BCD_W-1:0]        shown;
   } dir_row_type;

   typedef struct packed {
      logic [bcds_pkg::DIGIT_W-1:0] digit;
      logic [bcds_pkg::CNT_W-1:0]   position;
      logic                         last;
   } digit_rec_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [bcds_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bcds_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bcds_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   bcds_req_if req_if ();
   bcds_rsp_if rsp_if ();

   binary_to_bcd_digit_serializer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   digit_rec_type              expected_digits [$];
   logic [bcds_pkg::CNT_W-1:0] digit_count_reg;
   int                         fail_count;
   int                         src_idle_pct;
   int                         sink_idle_pct;
   bit                         hold_request;
   int                         stall_cycles;

   // Rows with the typed flag carry the expected digits, right-aligned in BCD.
   dir_row_type directed_rows [0:NUM_ROWS-1] = '{
      '{ROW_VALUE, '0, 32'd0,          1'b1, 40'h000},
      '{ROW_VALUE, '0, 32'd999,        1'b1, 40'h999},
      '{ROW_VALUE, '0, 32'd1000,       1'b1, 40'h000},
      '{ROW_VALUE, '0, 32'hFFFF_FFFF,  1'b1, 40'h295},
      '{ROW_VALUE, '0, 32'd123,        1'b0, 40'h0},
      '{ROW_WRITE, ADDR_DIGIT_COUNT, 32'd10, 1'b0, 40'h0},
      '{ROW_VALUE, '0, 32'hFFFF_FFFF,  1'b1, 40'h42_9496_7295},
      '{ROW_VALUE, '0, 32'd0,          1'b1, 40'h00_0000_0000},
      '{ROW_VALUE, '0, 32'd1000000000, 1'b1, 40'h10_0000_0000},
      '{ROW_VALUE, '0, 32'h8000_0000,  1'b1, 40'h21_4748_3648},
      '{ROW_VALUE, '0, 32'hAAAA_AAAA,  1'b0, 40'h0},
      '{ROW_VALUE, '0, 32'h5555_5555,  1'b0, 40'h0},
      '{ROW_WRITE, ADDR_UNMAPPED, 32'd1, 1'b0, 40'h0},
      '{ROW_VALUE, '0, 32'd987654321,  1'b1, 40'h09_8765_4321},
      '{ROW_WRITE, ADDR_DIGIT_COUNT, 32'hFFFF_FFF0, 1'b0, 40'h0},
      '{ROW_VALUE, '0, 32'd12345,      1'b1, 40'h0},
      '{ROW_VALUE, '0, 32'hFFFF_FFFF,  1'b1, 40'h0},
      '{ROW_WRITE, ADDR_DIGIT_COUNT, 32'd15, 1'b0, 40'h0},
      '{ROW_VALUE, '0, 32'hFFFF_FFFF,  1'b1, 40'h42_9496_7295},
      '{ROW_WRITE, ADDR_DIGIT_COUNT, 32'd11, 1'b0, 40'h0},
      '{ROW_VALUE, '0, 32'd1234567890, 1'b1, 40'h12_3456_7890},
      '{ROW_WRITE, ADDR_DIGIT_COUNT, 32'd1, 1'b0, 40'h0},
      '{ROW_VALUE, '0, 32'd7,          1'b1, 40'h7},
      '{ROW_VALUE, '0, 32'hFFFF_FFFF,  1'b1, 40'h5},
      '{ROW_VALUE, '0, 32'd10,         1'b1, 40'h0},
      '{ROW_WRITE, ADDR_DIGIT_COUNT, 32'h1234_5672, 1'b0, 40'h0},
      '{ROW_VALUE, '0, 32'd99,         1'b1, 40'h99},
      '{ROW_VALUE, '0, 32'd100,        1'b1, 40'h00},
      '{ROW_VALUE, '0, 32'd2017,       1'b0, 40'h0}
   };

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endfunction

   // Counts above the digit capacity behave as the full ten digits.
   function automatic int unsigned shown_count();
      return (digit_count_reg > bcds_pkg::MAX_DIGITS) ? bcds_pkg::MAX_DIGITS
                                                      : digit_count_reg;
   endfunction

   // Low n decimal digits of v, least significant digit in the low nibble.
   function automatic logic [bcds_pkg::BCD_W-1:0] to_decimal(
      logic [bcds_pkg::VALUE_W-1:0] v, int unsigned n);
      logic [bcds_pkg::BCD_W-1:0]   bcd;
      logic [bcds_pkg::VALUE_W-1:0] rest;
      bcd  = '0;
      rest = v;
      for (int k = 0; k < n; k++) begin
         bcd[k*bcds_pkg::DIGIT_W +: bcds_pkg::DIGIT_W] = bcds_pkg::DIGIT_W'(rest % 10);
         rest = rest / 10;
      end
      return bcd;
   endfunction

   // Digits leave most significant first, position 0 being the leftmost.
   function automatic void queue_digits(logic [bcds_pkg::BCD_W-1:0] bcd);
      int unsigned   n;
      digit_rec_type rec;
      n = shown_count();
      for (int k = 0; k < n; k++) begin
         rec.digit    = bcd[(n-1-k)*bcds_pkg::DIGIT_W +: bcds_pkg::DIGIT_W];
         rec.position = bcds_pkg::CNT_W'(k);
         rec.last     = (k == n - 1);
         expected_digits.push_back(rec);
      end
   endfunction

   function automatic logic [bcds_pkg::VALUE_W-1:0] random_value();
      logic [bcds_pkg::VALUE_W-1:0] p;
      p = 1;
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 999);
         2: begin
            repeat ($urandom_range(1, 9)) p = p * 10;
            return p - 1 + $urandom_range(0, 2);
         end
         default: return 32'hFFFF_FFFF - $urandom_range(0, 9);
      endcase
   endfunction

   task automatic offer_value(input logic [bcds_pkg::VALUE_W-1:0] v, input bit typed,
                              input logic [bcds_pkg::BCD_W-1:0] shown);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         req_if.value <= $urandom;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      queue_digits(typed ? shown : to_decimal(v, shown_count()));
   endtask

   // Waits for every expected digit, then lets the pipeline empty of values
   // that produce no digits at all.
   task automatic quiesce();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [bcds_pkg::CSR_ADDR_W-1:0] addr,
                                 input logic [bcds_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_DIGIT_COUNT) digit_count_reg = data[bcds_pkg::CNT_W-1:0];
      // Read the count back; a write to an unmapped address must leave it alone.
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_DIGIT_COUNT;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== bcds_pkg::CSR_DATA_W'(digit_count_reg)) begin
         note_failure($sformatf("digit_count read back exp %0d got %0h",
                                digit_count_reg, csr_prdata));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Result side: random back-pressure, or one long stall when asked for.
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left    = 0;
      hold_taken   = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      digit_rec_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_digits.size() == 0) begin
            note_failure($sformatf("unexpected digit %0d at position %0d",
                                   rsp_if.bcd_digit, rsp_if.position));
         end else begin
            want = expected_digits.pop_front();
            if (rsp_if.bcd_digit !== want.digit) begin
               note_failure($sformatf("bcd_digit exp %0d got %0h", want.digit,
                                      rsp_if.bcd_digit));
            end
            if (rsp_if.position !== want.position) begin
               note_failure($sformatf("position exp %0d got %0h", want.position,
                                      rsp_if.position));
            end
            if (rsp_if.last !== want.last) begin
               note_failure($sformatf("last exp %0b got %0b at position %0d", want.last,
                                      rsp_if.last, want.position));
            end
         end
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("** binary_to_bcd_digit_serializer_core: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      dir_row_type row;
      int unsigned block_count [0:NUM_BLOCKS-1];
      int unsigned n_items;

      fail_count      = 0;
      hold_request    = 1'b0;
      digit_count_reg = bcds_pkg::CNT_W'(3);
      src_idle_pct    = 38;
      sink_idle_pct   = 70;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.value    = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         row = directed_rows[r];
         if (row.kind == ROW_WRITE) begin
            quiesce();
            write_register(row.addr, row.word);
         end else begin
            offer_value(row.word, row.typed, row.shown);
         end
      end

      block_count = '{10, 1, 15, 0, $urandom_range(2, 9), 12, $urandom_range(1, 9), 10, 3};
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (b < 3) begin
            src_idle_pct  = 38;
            sink_idle_pct = 70;
         end else if (b < 6) begin
            src_idle_pct  = 70;
            sink_idle_pct = 38;
         end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         quiesce();
         write_register(ADDR_DIGIT_COUNT,
                        {PAD_W'($urandom_range(0, 2**PAD_W - 1)),
                         bcds_pkg::CNT_W'(block_count[b])});
         // Stall the result side at full rate so the input backs up.
         if (b == 7) hold_request = 1'b1;
         n_items = (block_count[b] == 0) ? 5 : 12;
         repeat (n_items) offer_value(random_value(), 1'b0, '0);
      end

      quiesce();
      if (fail_count == 0) begin
         $display("** binary_to_bcd_digit_serializer_core: PASSED **");
      end else begin
         $display("** binary_to_bcd_digit_serializer_core: FAILED **");
      end
      $finish;
   end

endmodule

>>> files.f
sv/bcds_pkg.sv
sv/bcds_req_if.sv
sv/bcds_rsp_if.sv
sv/bcds_convert.sv
sv/bcds_serial.sv
sv/binary_to_bcd_digit_serializer_core.sv
sv/bcds_checker.sv
verif/tb_top.sv
